FILE: hw/rtl/bblur_pkg.sv
package bblur_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_HEIGHT  = 4096;

    localparam int PIX_W       = 8;
    localparam int CFG_W       = 13;
    localparam int CMP_W       = CFG_W + 1;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int IN_ROW_W    = $clog2(MAX_HEIGHT + 2);
    localparam int OUT_ROW_W   = $clog2(MAX_HEIGHT);
    localparam int LINE_W      = 2 * PIX_W;
    localparam int SUM_W       = $clog2(9 * ((1 << PIX_W) - 1) + 1);
    localparam int CNT_W       = 4;
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;

    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;
    localparam int REG_SEL_BIT = 2;

    // register index codes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // ceil(2^16 / d): exact truncating divide for sums below 2^SUM_W
    localparam logic [RECIP_W-1:0] RECIP_1 = RECIP_W'(1 << RECIP_SHIFT);
    localparam logic [RECIP_W-1:0] RECIP_2 = RECIP_W'((1 << RECIP_SHIFT) / 2);
    localparam logic [RECIP_W-1:0] RECIP_3 = RECIP_W'(((1 << RECIP_SHIFT) + 2) / 3);
    localparam logic [RECIP_W-1:0] RECIP_4 = RECIP_W'((1 << RECIP_SHIFT) / 4);
    localparam logic [RECIP_W-1:0] RECIP_6 = RECIP_W'(((1 << RECIP_SHIFT) + 5) / 6);
    localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'(((1 << RECIP_SHIFT) + 8) / 9);

    typedef struct packed {
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] height;
        logic             restart;
    } t_cfg;

    typedef struct packed {
        logic capture;
        logic step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic noop;
        logic emit;
    } t_status;

    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                   input logic [CFG_W-1:0] max_v);
        logic [CFG_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = CFG_W'(1);
        end else if (v > max_v) begin
            r = max_v;
        end
        return r;
    endfunction

    function automatic logic [RECIP_W-1:0] recip_of(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] m;
        unique case (cnt)
            CNT_W'(2): m = RECIP_2;
            CNT_W'(3): m = RECIP_3;
            CNT_W'(4): m = RECIP_4;
            CNT_W'(6): m = RECIP_6;
            CNT_W'(9): m = RECIP_9;
            default:   m = RECIP_1;
        endcase
        return m;
    endfunction

endpackage

FILE: hw/rtl/bblur_in_if.sv
interface bblur_in_if;
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [bblur_pkg::PIX_W-1:0] pixel_in;

    modport source (output valid, output action, output pixel_in, input ready);
    modport sink   (input valid, input action, input pixel_in, output ready);
endinterface

FILE: hw/rtl/bblur_out_if.sv
interface bblur_out_if;
    logic                        valid;
    logic                        ready;
    logic [bblur_pkg::PIX_W-1:0] pixel_out;
    logic                        frame_last;

    modport source (output valid, output pixel_out, output frame_last, input ready);
    modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

FILE: hw/rtl/bblur_ram.sv
module bblur_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/bblur_cfg.sv
module bblur_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bblur_pkg::APB_AW-1:0]    paddr,
    input  logic [bblur_pkg::APB_DW-1:0]    pwdata,
    output logic [bblur_pkg::APB_DW-1:0]    prdata,
    output bblur_pkg::t_cfg                 o_cfg
);

    logic [bblur_pkg::CFG_W-1:0] r_width, n_width;
    logic [bblur_pkg::CFG_W-1:0] r_height, n_height;
    logic                        wr_en;
    logic [bblur_pkg::CFG_W-1:0] wr_val;

    assign wr_en  = psel && penable && pwrite;
    assign wr_val = pwdata[bblur_pkg::CFG_W-1:0];

    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        if (wr_en) begin
            unique case (paddr[bblur_pkg::REG_SEL_BIT])
                bblur_pkg::REG_WIDTH: begin
                    n_width = bblur_pkg::clamp_dim(wr_val,
                                                   bblur_pkg::CFG_W'(bblur_pkg::MAX_WIDTH));
                end
                bblur_pkg::REG_HEIGHT: begin
                    n_height = bblur_pkg::clamp_dim(wr_val,
                                                    bblur_pkg::CFG_W'(bblur_pkg::MAX_HEIGHT));
                end
                default: begin
                    n_width = r_width;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= bblur_pkg::CFG_W'(bblur_pkg::MAX_WIDTH);
            r_height <= bblur_pkg::CFG_W'(bblur_pkg::MAX_HEIGHT);
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
        end
    end

    always_comb begin
        unique case (paddr[bblur_pkg::REG_SEL_BIT])
            bblur_pkg::REG_HEIGHT: prdata = bblur_pkg::APB_DW'(r_height);
            default:               prdata = bblur_pkg::APB_DW'(r_width);
        endcase
    end

    // any size write restarts the frame
    assign o_cfg.width   = r_width;
    assign o_cfg.height  = r_height;
    assign o_cfg.restart = wr_en;

endmodule

FILE: hw/rtl/bblur_ctrl.sv
module bblur_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  bblur_pkg::t_status  i_st,
    output bblur_pkg::t_cmd     o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOAD = 3'b010,
        S_MUL  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   out_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // a drain inside the frame is taken and dropped
    assign o_cmd.capture  = accept && !i_st.noop;
    assign o_cmd.step     = (r_state == S_LOAD);
    assign o_cmd.out_load = (r_state == S_MUL) && out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.capture) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = i_st.emit ? S_MUL : S_IDLE;
            end
            S_MUL: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result register loaded while holding an untaken result");

    a_out_from_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_MUL))
        else $error("result appeared without a multiply step");
`endif

endmodule

FILE: hw/rtl/bblur_dp.sv
module bblur_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bblur_pkg::t_cmd              i_cmd,
    output bblur_pkg::t_status           o_st,
    input  bblur_pkg::t_cfg              i_cfg,
    input  logic                         i_action,
    input  logic [bblur_pkg::PIX_W-1:0]  i_pixel,
    output logic [bblur_pkg::PIX_W-1:0]  o_pixel_out,
    output logic                         o_frame_last
);

    localparam int PIX_W = bblur_pkg::PIX_W;
    localparam int CMP_W = bblur_pkg::CMP_W;
    localparam int COL_W = bblur_pkg::COL_W;
    localparam int IRW   = bblur_pkg::IN_ROW_W;
    localparam int ORW   = bblur_pkg::OUT_ROW_W;
    localparam int SUM_W = bblur_pkg::SUM_W;
    localparam int CNT_W = bblur_pkg::CNT_W;
    localparam int RCP_W = bblur_pkg::RECIP_W;

    logic [COL_W-1:0] r_in_col, n_in_col;
    logic [IRW-1:0]   r_in_row, n_in_row;
    logic [COL_W-1:0] r_out_col, n_out_col;
    logic [ORW-1:0]   r_out_row, n_out_row;

    logic [PIX_W-1:0] r_win [3][3];
    logic [PIX_W-1:0] r_px;
    logic [SUM_W-1:0] r_sum;
    logic [RCP_W-1:0] r_recip;
    logic             r_last;
    logic [PIX_W-1:0] r_pixel_out;
    logic             r_frame_last;

    logic [bblur_pkg::LINE_W-1:0] rdata;
    logic [PIX_W-1:0]             col_in [3];

    logic [CMP_W-1:0] width_c, height_c;
    logic [CMP_W-1:0] in_col_inc, out_col_inc, out_row_inc;
    logic             in_active;
    logic             x_zero, emit_a, emit_b, emit, last;
    logic             top_ok, bot_ok, left_ok, right_ok;
    logic [2:0]       row_ok;
    logic [1:0]       rows_n, cols_n;
    logic [CNT_W-1:0] cnt;
    logic [SUM_W-1:0] sum;
    logic [bblur_pkg::PROD_W-1:0] prod;

    assign width_c     = CMP_W'(i_cfg.width);
    assign height_c    = CMP_W'(i_cfg.height);
    assign in_col_inc  = CMP_W'(r_in_col) + CMP_W'(1);
    assign out_col_inc = CMP_W'(r_out_col) + CMP_W'(1);
    assign out_row_inc = CMP_W'(r_out_row) + CMP_W'(1);

    // past the last row every item acts as a drain
    assign in_active = CMP_W'(r_in_row) < height_c;
    assign o_st.noop = i_action && in_active;

    bblur_ram #(
        .WIDTH (bblur_pkg::LINE_W),
        .DEPTH (bblur_pkg::MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (i_cmd.step),
        .i_waddr (r_in_col),
        .i_wdata ({rdata[PIX_W-1:0], r_px}),
        .i_re    (i_cmd.capture),
        .i_raddr (r_in_col),
        .o_rdata (rdata)
    );

    assign col_in[0] = rdata[2*PIX_W-1:PIX_W];
    assign col_in[1] = rdata[PIX_W-1:0];
    assign col_in[2] = r_px;

    // first column of a row flushes the right edge of the row two up
    assign x_zero = (r_in_col == '0);
    assign emit_a = x_zero && (CMP_W'(r_in_row) >= CMP_W'(2));
    assign emit_b = !x_zero && (CMP_W'(r_in_row) >= CMP_W'(1));
    assign emit   = emit_a || emit_b;
    assign o_st.emit = emit;

    assign last = (CMP_W'(r_out_row) == height_c - CMP_W'(1)) &&
                  (CMP_W'(r_out_col) == width_c - CMP_W'(1));

    // left and center always sit in the two newest window columns
    assign top_ok   = (r_out_row != '0);
    assign bot_ok   = out_row_inc < height_c;
    assign left_ok  = (r_out_col != '0);
    assign right_ok = emit_b && (out_col_inc < width_c);
    assign row_ok   = {bot_ok, 1'b1, top_ok};
    assign rows_n   = 2'(1) + 2'(top_ok) + 2'(bot_ok);
    assign cols_n   = 2'(1) + 2'(left_ok) + 2'(right_ok);
    assign cnt      = CNT_W'(rows_n) * CNT_W'(cols_n);

    always_comb begin
        sum = '0;
        for (int r = 0; r < 3; r++) begin
            if (row_ok[r]) begin
                if (left_ok) begin
                    sum = sum + SUM_W'(r_win[r][1]);
                end
                sum = sum + SUM_W'(r_win[r][2]);
                if (right_ok) begin
                    sum = sum + SUM_W'(col_in[r]);
                end
            end
        end
    end

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (i_cfg.restart) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end else if (i_cmd.step) begin
            if (emit) begin
                if (out_col_inc >= width_c) begin
                    n_out_col = '0;
                    n_out_row = out_row_inc[ORW-1:0];
                end else begin
                    n_out_col = out_col_inc[COL_W-1:0];
                end
            end
            if (in_col_inc >= width_c) begin
                n_in_col = '0;
                n_in_row = r_in_row + IRW'(1);
            end else begin
                n_in_col = in_col_inc[COL_W-1:0];
            end
            // last output of the frame: start over
            if (emit && last) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_px <= in_active ? i_pixel : '0;
        end
        if (i_cmd.step) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
                r_win[r][2] <= col_in[r];
            end
            if (emit) begin
                r_sum   <= sum;
                r_recip <= bblur_pkg::recip_of(cnt);
                r_last  <= last;
            end
        end
        if (i_cmd.out_load) begin
            r_pixel_out  <= prod[bblur_pkg::RECIP_SHIFT +: PIX_W];
            r_frame_last <= r_last;
        end
    end

    assign prod = bblur_pkg::PROD_W'(r_sum) * bblur_pkg::PROD_W'(r_recip);

    assign o_pixel_out  = r_pixel_out;
    assign o_frame_last = r_frame_last;

`ifndef ASSERT_OFF
    a_col_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_in_col) < width_c)
        else $error("input column ran past the configured width");

    a_out_lag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && emit_b) |-> (r_out_col + COL_W'(1) == r_in_col))
        else $error("output column lost step with input column");
`endif

endmodule

FILE: hw/rtl/box_blur_3x3_stream.sv
// A request is accepted only in the idle state; its pixel and the line-memory read are registered.
// A request with a result then takes the window/sum step and the reciprocal multiply stage,
// which loads the output register once it is free; one without a result skips the multiply,
// and an in-frame drain is taken and dropped. Requests are done one at a time.
// Reset (synchronous, active low) clears the position counters and handshake state and
// sets width and height to 4096; the line memory is not cleared.
module box_blur_3x3_stream (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    bblur_in_if.sink                     i_in,
    bblur_out_if.source                  o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bblur_pkg::APB_AW-1:0] paddr,
    input  logic [bblur_pkg::APB_DW-1:0] pwdata,
    output logic [bblur_pkg::APB_DW-1:0] prdata,
    output logic                         pready
);

    bblur_pkg::t_cfg    cfg;
    bblur_pkg::t_cmd    cmd;
    bblur_pkg::t_status st;

    assign pready = 1'b1;

    bblur_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    bblur_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_st        (st),
        .o_cmd       (cmd)
    );

    bblur_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_st         (st),
        .i_cfg        (cfg),
        .i_action     (i_in.action),
        .i_pixel      (i_in.pixel_in),
        .o_pixel_out  (o_out.pixel_out),
        .o_frame_last (o_out.frame_last)
    );

endmodule
